@@ rtl/ple_pkg.sv @@
// Shared types and constants for the positional list engine.
// No dependencies; every other file refers to this package by scoped names.
package ple_pkg;

   localparam int DEPTH  = 64;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int DATA_W = 32;
   localparam int OP_W   = 3;
   localparam int POS_W  = 6;
   localparam int STAT_W = 2;

   typedef enum logic [OP_W-1:0] {
      OP_INS_FRONT = 3'd0,
      OP_INS_BACK  = 3'd1,
      OP_INS_AT    = 3'd2,
      OP_DEL_FRONT = 3'd3,
      OP_DEL_BACK  = 3'd4,
      OP_DEL_AT    = 3'd5,
      OP_READ      = 3'd6
   } opcode_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ACT_HOLD,
      ACT_INSERT,
      ACT_DELETE
   } action_type;

   // Broadcast from the controller to every cell of the chain.
   typedef struct packed {
      action_type              action;
      logic [IDX_W-1:0]        at;
      logic signed [DATA_W-1:0] value;
   } cell_ctrl_type;

   // Outcome of the current request, used to build the result.
   typedef struct packed {
      status_type       status;
      logic             take_value;
      logic [IDX_W-1:0] at;
      logic [CNT_W-1:0] count;
   } req_result_type;

endpackage

@@ rtl/ple_req_if.sv @@
// Request channel: valid/ready handshake with opcode, position and value.
// Depends on ple_pkg for field widths.
interface ple_req_if;
   logic                              valid;
   logic                              ready;
   logic [ple_pkg::OP_W-1:0]          opcode;
   logic [ple_pkg::POS_W-1:0]         position;
   logic signed [ple_pkg::DATA_W-1:0] value_in;

   modport source (output valid, opcode, position, value_in, input ready);
   modport sink   (input valid, opcode, position, value_in, output ready);
endinterface

@@ rtl/ple_rsp_if.sv @@
// Response channel: valid/ready handshake with status, value and count.
// Depends on ple_pkg for field widths.
interface ple_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [ple_pkg::STAT_W-1:0]        status;
   logic signed [ple_pkg::DATA_W-1:0] value_out;
   logic [ple_pkg::CNT_W-1:0]         count;

   modport source (output valid, status, value_out, count, input ready);
   modport sink   (input valid, status, value_out, count, output ready);
endinterface

@@ rtl/ple_cell.sv @@
// One storage cell of the list chain: holds one element and shifts with its neighbors.
// Depends on ple_pkg for the cell control struct.
module ple_cell (
   input  logic                              clock,
   input  logic [ple_pkg::IDX_W-1:0]         idx,
   input  ple_pkg::cell_ctrl_type            ctrl,
   input  logic signed [ple_pkg::DATA_W-1:0] prev_q,
   input  logic signed [ple_pkg::DATA_W-1:0] next_q,
   output logic signed [ple_pkg::DATA_W-1:0] data_q
);

   logic signed [ple_pkg::DATA_W-1:0] data_ff;
   logic signed [ple_pkg::DATA_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      case (ctrl.action)
         ple_pkg::ACT_INSERT: begin
            if (idx > ctrl.at) begin
               data_in = prev_q;
            end else if (idx == ctrl.at) begin
               data_in = ctrl.value;
            end
         end
         ple_pkg::ACT_DELETE: begin
            // Entries past the count may pick up stale data; they are never read.
            if (idx >= ctrl.at) begin
               data_in = next_q;
            end
         end
         default: data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_q = data_ff;

endmodule

@@ rtl/ple_ctrl.sv @@
// Request decoder and element counter: checks each request and drives the cell chain.
// Depends on ple_pkg for opcodes, status codes and the control structs.
module ple_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  logic [ple_pkg::OP_W-1:0]          opcode,
   input  logic [ple_pkg::POS_W-1:0]         position,
   input  logic signed [ple_pkg::DATA_W-1:0] value_in,
   output ple_pkg::cell_ctrl_type            cell_ctrl,
   output ple_pkg::req_result_type           result
);

   logic [ple_pkg::CNT_W-1:0] count_ff;
   logic [ple_pkg::CNT_W-1:0] count_in;
   logic [ple_pkg::CNT_W-1:0] count_new;
   logic [ple_pkg::CNT_W-1:0] at_full;
   logic [ple_pkg::CNT_W-1:0] pos_ext;
   ple_pkg::status_type       status;
   ple_pkg::action_type       action;
   logic                      take_value;

   assign pos_ext = ple_pkg::CNT_W'(position);

   always_comb begin
      status     = ple_pkg::ST_OK;
      action     = ple_pkg::ACT_HOLD;
      take_value = 1'b0;
      at_full    = '0;
      unique case (ple_pkg::opcode_type'(opcode)) inside
         ple_pkg::OP_INS_FRONT, ple_pkg::OP_INS_BACK, ple_pkg::OP_INS_AT: begin
            if (ple_pkg::opcode_type'(opcode) == ple_pkg::OP_INS_BACK) begin
               at_full = count_ff;
            end else if (ple_pkg::opcode_type'(opcode) == ple_pkg::OP_INS_AT) begin
               at_full = pos_ext;
            end
            if (count_ff == ple_pkg::CNT_W'(ple_pkg::DEPTH)) begin
               status = ple_pkg::ST_FULL;
            end else if (at_full > count_ff) begin
               status = ple_pkg::ST_RANGE;
            end else begin
               action = ple_pkg::ACT_INSERT;
            end
         end
         ple_pkg::OP_DEL_FRONT, ple_pkg::OP_DEL_BACK, ple_pkg::OP_DEL_AT,
         ple_pkg::OP_READ: begin
            if (ple_pkg::opcode_type'(opcode) == ple_pkg::OP_DEL_BACK) begin
               at_full = count_ff - 1'b1;
            end else if (ple_pkg::opcode_type'(opcode) == ple_pkg::OP_DEL_AT ||
                         ple_pkg::opcode_type'(opcode) == ple_pkg::OP_READ) begin
               at_full = pos_ext;
            end
            if (count_ff == '0) begin
               status = ple_pkg::ST_EMPTY;
            end else if (at_full >= count_ff) begin
               status = ple_pkg::ST_RANGE;
            end else begin
               take_value = 1'b1;
               if (ple_pkg::opcode_type'(opcode) != ple_pkg::OP_READ) begin
                  action = ple_pkg::ACT_DELETE;
               end
            end
         end
         default: begin
            // The unused opcode is ignored and reports success.
            status = ple_pkg::ST_OK;
         end
      endcase
   end

   always_comb begin
      count_new = count_ff;
      if (action == ple_pkg::ACT_INSERT) begin
         count_new = count_ff + 1'b1;
      end else if (action == ple_pkg::ACT_DELETE) begin
         count_new = count_ff - 1'b1;
      end
      count_in = accept ? count_new : count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign cell_ctrl.action = accept ? action : ple_pkg::ACT_HOLD;
   assign cell_ctrl.at     = at_full[ple_pkg::IDX_W-1:0];
   assign cell_ctrl.value  = value_in;

   assign result.status     = status;
   assign result.take_value = take_value;
   assign result.at         = at_full[ple_pkg::IDX_W-1:0];
   assign result.count      = count_new;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= ple_pkg::CNT_W'(ple_pkg::DEPTH))
      else $error("element count above list depth");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      accept && cell_ctrl.action == ple_pkg::ACT_INSERT
      |=> count_ff == ple_pkg::CNT_W'($past(count_ff) + 1'b1))
      else $error("insert did not grow the count by one");

   a_delete_shrinks: assert property (@(posedge clock) disable iff (reset)
      accept && cell_ctrl.action == ple_pkg::ACT_DELETE
      |=> count_ff == ple_pkg::CNT_W'($past(count_ff) - 1'b1))
      else $error("delete did not shrink the count by one");

   a_fail_keeps: assert property (@(posedge clock) disable iff (reset)
      accept && status != ple_pkg::ST_OK |=> $stable(count_ff))
      else $error("failed request changed the count");

endmodule

@@ rtl/positional_list_engine.sv @@
// Positional list engine: ordered list of signed 32-bit values in a chain of cells.
// Depends on ple_pkg, ple_req_if, ple_rsp_if, ple_ctrl and ple_cell.
//
//   channel   direction  handshake      payload
//   req_chan  in         valid/ready    opcode, position, value_in
//   rsp_chan  out        valid/ready    status, value_out, count
//
// Every request is applied to all cells in the cycle of its transfer, so one
// request completes per clock; the result appears in the output register on the
// next cycle. Requests keep flowing while a result waits, unless the result
// register is full and the response side is not ready. Reset empties the list
// and drops any pending result; cell contents are left as they are.
module positional_list_engine (
   input  logic           clock,
   input  logic           reset,
   ple_req_if.sink        req_chan,
   ple_rsp_if.source      rsp_chan
);

   ple_pkg::cell_ctrl_type            cell_ctrl;
   ple_pkg::req_result_type           result;
   logic signed [ple_pkg::DATA_W-1:0] cell_q [ple_pkg::DEPTH];
   logic signed [ple_pkg::DATA_W-1:0] sel_value;
   logic                              accept;

   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   logic [ple_pkg::STAT_W-1:0]        rsp_status_ff;
   logic signed [ple_pkg::DATA_W-1:0] rsp_value_ff;
   logic [ple_pkg::CNT_W-1:0]         rsp_count_ff;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   ple_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .opcode    (req_chan.opcode),
      .position  (req_chan.position),
      .value_in  (req_chan.value_in),
      .cell_ctrl (cell_ctrl),
      .result    (result)
   );

   for (genvar g = 0; g < ple_pkg::DEPTH; g++) begin : g_cell
      logic signed [ple_pkg::DATA_W-1:0] prev_q;
      logic signed [ple_pkg::DATA_W-1:0] next_q;

      if (g == 0) begin : g_first
         assign prev_q = cell_q[g];
      end else begin : g_prev
         assign prev_q = cell_q[g-1];
      end
      if (g == ple_pkg::DEPTH - 1) begin : g_last
         assign next_q = cell_q[g];
      end else begin : g_next
         assign next_q = cell_q[g+1];
      end

      ple_cell u_cell (
         .clock  (clock),
         .idx    (ple_pkg::IDX_W'(g)),
         .ctrl   (cell_ctrl),
         .prev_q (prev_q),
         .next_q (next_q),
         .data_q (cell_q[g])
      );
   end

   // The removed or read element is taken before the chain shifts.
   assign sel_value = result.take_value ? cell_q[result.at] : '0;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff <= result.status;
         rsp_value_ff  <= sel_value;
         rsp_count_ff  <= result.count;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.status    = rsp_status_ff;
   assign rsp_chan.value_out = rsp_value_ff;
   assign rsp_chan.count     = rsp_count_ff;

endmodule
